FILE: rtl/gapd_pkg.sv
// ----------------------------------------------------------------------------
// gapd_pkg
// Shared types, register codes, reset values and microcode for the gimbal
// aim PD filter step.
// ----------------------------------------------------------------------------
package gapd_pkg;

  localparam int unsigned NumCfgRegs = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned StepW      = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEAD_ZONE      = 3'd0,
    CFG_YAW_PROP_GAIN  = 3'd1,
    CFG_YAW_DERIV_GAIN = 3'd2,
    CFG_SMOOTH_FACTOR  = 3'd3,
    CFG_STALE_LIMIT_MS = 3'd4,
    CFG_DECAY_FACTOR   = 3'd5,
    CFG_YAW_TRIM       = 3'd6,
    CFG_PITCH_TRIM     = 3'd7
  } gapd_cfg_idx_e;

  localparam logic        [14:0] DeadZoneRst     = 15'd20;
  localparam logic signed [15:0] YawPropGainRst  = -16'sd7373;
  localparam logic signed [15:0] YawDerivGainRst = -16'sd614;
  localparam logic        [15:0] SmoothFactorRst = 16'd22938;
  localparam logic        [15:0] StaleLimitRst   = 16'd300;
  localparam logic        [15:0] DecayFactorRst  = 16'd62259;
  localparam logic signed [15:0] YawTrimRst      = 16'sd164;
  localparam logic signed [15:0] PitchTrimRst    = 16'sd410;

  typedef struct packed {
    logic        [14:0] dead_zone;
    logic signed [15:0] yaw_prop_gain;
    logic signed [15:0] yaw_deriv_gain;
    logic        [15:0] smooth_factor;
    logic        [15:0] stale_limit_ms;
    logic        [15:0] decay_factor;
    logic signed [15:0] yaw_trim;
    logic signed [15:0] pitch_trim;
  } gapd_cfg_t;

  typedef struct packed {
    logic signed [15:0] yaw_error;
    logic signed [15:0] pitch_error;
    logic               shutdown;
    logic        [31:0] now_ms;
    logic               aim_fire;
    logic               trigger_held;
  } gapd_in_t;

  typedef struct packed {
    logic               gimbal_enabled;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_cmd;
    logic               firing;
  } gapd_out_t;

  // Microcode fields
  typedef enum logic [1:0] {
    SEQ_NEXT  = 2'd0,
    SEQ_JSHUT = 2'd1,
    SEQ_END   = 2'd2
  } gapd_seq_e;

  typedef enum logic [1:0] {
    MA_YAW   = 2'd0,
    MA_YDIFF = 2'd1,
    MA_PDIFF = 2'd2,
    MA_PF    = 2'd3
  } gapd_mul_a_e;

  typedef enum logic [1:0] {
    MB_KP    = 2'd0,
    MB_KD    = 2'd1,
    MB_ALPHA = 2'd2,
    MB_DECAY = 2'd3
  } gapd_mul_b_e;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } gapd_acc_e;

  typedef struct packed {
    gapd_seq_e        seq;
    logic [StepW-1:0] target;
    gapd_mul_a_e      mul_a;
    gapd_mul_b_e      mul_b;
    logic             mul_en;
    gapd_acc_e        acc_op;
    logic             prep;
    logic             age;
    logic             pf_upd;
    logic             prev_upd;
    logic             decay;
    logic             shut;
    logic             emit;
  } gapd_uword_t;

  localparam logic [StepW-1:0] StepShut = 3'd7;

  function automatic gapd_uword_t gapd_urom(logic [StepW-1:0] addr);
    gapd_uword_t w;
    w          = '0;
    w.seq      = SEQ_NEXT;
    w.mul_a    = MA_YAW;
    w.mul_b    = MB_KP;
    w.acc_op   = ACC_NONE;
    unique case (addr)
      3'd0: begin
        // dead zone, refresh time stamp, branch on shutdown
        w.prep   = 1'b1;
        w.seq    = SEQ_JSHUT;
        w.target = StepShut;
      end
      3'd1: begin
        w.age    = 1'b1;
        w.mul_en = 1'b1;
      end
      3'd2: begin
        w.mul_a  = MA_YDIFF;
        w.mul_b  = MB_KD;
        w.mul_en = 1'b1;
        w.acc_op = ACC_LOAD;
      end
      3'd3: begin
        w.mul_a  = MA_PDIFF;
        w.mul_b  = MB_ALPHA;
        w.mul_en = 1'b1;
        w.acc_op = ACC_ADD;
      end
      3'd4: begin
        w.pf_upd   = 1'b1;
        w.prev_upd = 1'b1;
      end
      3'd5: begin
        w.mul_a  = MA_PF;
        w.mul_b  = MB_DECAY;
        w.mul_en = 1'b1;
      end
      3'd6: begin
        w.decay = 1'b1;
        w.emit  = 1'b1;
        w.seq   = SEQ_END;
      end
      3'd7: begin
        w.shut = 1'b1;
        w.emit = 1'b1;
        w.seq  = SEQ_END;
      end
      default: begin
        w.seq = SEQ_END;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [15:0] gapd_sat16(logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/gimbal_aim_pd_filter_step.sv
// ----------------------------------------------------------------------------
// gimbal_aim_pd_filter_step
// Per-tick gimbal aim step: dead zone, yaw PD, pitch smoothing, timeout
// decay, trims and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on in_valid_i / in_data_i and are taken when
//   in_stall_o is low. One result beat leaves on out_valid_o / out_data_o,
//   taken when out_stall_i is low. Registers are written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i, by the user only while no beat is in
//   flight; the block itself does not enforce this. A normal beat runs
//   seven microcode steps on one shared multiplier before its result is
//   registered; a shutdown beat branches straight to its final step.
//   The input stays stalled until the last step, so a new beat is taken
//   only after the previous beat's program has run out. The last step
//   waits while a previous result still sits stalled in the output
//   register, so a stalled receiver holds the block after one more beat
//   has been taken.
//   Reset clears the sequencer, the output valid, the filter state and
//   restores the default register values.
// ----------------------------------------------------------------------------
module gimbal_aim_pd_filter_step (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gapd_pkg::gapd_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gapd_pkg::gapd_out_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [gapd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gapd_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import gapd_pkg::*;

  gapd_cfg_t   cfg_q;
  gapd_in_t    in_q;
  gapd_out_t   out_q, res;
  logic        out_valid_q;
  gapd_uword_t uword;
  logic        go, busy, emit_ok, in_accept;

  assign in_accept = in_valid_i && !busy;
  assign in_stall_o = busy;
  assign emit_ok   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone      <= DeadZoneRst;
      cfg_q.yaw_prop_gain  <= YawPropGainRst;
      cfg_q.yaw_deriv_gain <= YawDerivGainRst;
      cfg_q.smooth_factor  <= SmoothFactorRst;
      cfg_q.stale_limit_ms <= StaleLimitRst;
      cfg_q.decay_factor   <= DecayFactorRst;
      cfg_q.yaw_trim       <= YawTrimRst;
      cfg_q.pitch_trim     <= PitchTrimRst;
    end else if (cfg_we_i) begin
      unique case (gapd_cfg_idx_e'(cfg_idx_i))
        CFG_DEAD_ZONE:      cfg_q.dead_zone      <= cfg_wdata_i[14:0];
        CFG_YAW_PROP_GAIN:  cfg_q.yaw_prop_gain  <= cfg_wdata_i;
        CFG_YAW_DERIV_GAIN: cfg_q.yaw_deriv_gain <= cfg_wdata_i;
        CFG_SMOOTH_FACTOR:  cfg_q.smooth_factor  <= cfg_wdata_i;
        CFG_STALE_LIMIT_MS: cfg_q.stale_limit_ms <= cfg_wdata_i;
        CFG_DECAY_FACTOR:   cfg_q.decay_factor   <= cfg_wdata_i;
        CFG_YAW_TRIM:       cfg_q.yaw_trim       <= cfg_wdata_i;
        CFG_PITCH_TRIM:     cfg_q.pitch_trim     <= cfg_wdata_i;
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  // hold the input beat for the whole program
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  gapd_useq u_useq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .shut_i    (in_q.shutdown),
    .emit_ok_i (emit_ok),
    .uword_o   (uword),
    .go_o      (go),
    .busy_o    (busy)
  );

  gapd_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .uword_i (uword),
    .go_i    (go),
    .in_i    (in_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && uword.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && uword.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while program still running");

  a_full_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_data_i.shutdown) |=> ##5 in_stall_o)
    else $error("normal beat finished before its microcode ran out");

  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.gimbal_enabled) |->
      (out_data_o.yaw_cmd == 16'sd0 && out_data_o.pitch_cmd == 16'sd0))
    else $error("disabled result carries a nonzero command");

endmodule

FILE: rtl/gapd_useq.sv
// ----------------------------------------------------------------------------
// gapd_useq
// Step counter and microcode fetch; one control word per step, with a
// shutdown branch and a final step that waits for the output register.
// ----------------------------------------------------------------------------
module gapd_useq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 shut_i,
  input  logic                 emit_ok_i,
  output gapd_pkg::gapd_uword_t uword_o,
  output logic                 go_o,
  output logic                 busy_o
);
  import gapd_pkg::*;

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  gapd_uword_t      uw;

  assign uw      = gapd_urom(step_q);
  assign uword_o = uw;
  assign go_o    = busy_q && ((uw.seq != SEQ_END) || emit_ok_i);
  assign busy_o  = busy_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else if (go_o) begin
      unique case (uw.seq)
        SEQ_NEXT:  step_d = step_q + 1'b1;
        SEQ_JSHUT: step_d = shut_i ? uw.target : step_q + 1'b1;
        SEQ_END:   busy_d = 1'b0;
        default:   busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

endmodule

FILE: rtl/gapd_dpath.sv
// ----------------------------------------------------------------------------
// gapd_dpath
// Shared 17x17 multiplier, yaw accumulator, filter state and result
// formatting, driven by the microcode word.
// ----------------------------------------------------------------------------
module gapd_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gapd_pkg::gapd_uword_t uword_i,
  input  logic                  go_i,
  input  gapd_pkg::gapd_in_t    in_i,
  input  gapd_pkg::gapd_cfg_t   cfg_i,
  output gapd_pkg::gapd_out_t   res_o
);
  import gapd_pkg::*;

  function automatic logic signed [15:0] dz_apply(logic signed [15:0] e, logic [14:0] dz);
    logic [16:0] mag;
    mag = e[15] ? (17'd0 - {e[15], e}) : {1'b0, e};
    return (mag < {2'b00, dz}) ? 16'sd0 : e;
  endfunction

  // architectural state
  logic signed [15:0] pf_q, pf_d;
  logic signed [15:0] prev_q, prev_d;
  logic        [31:0] last_q, last_d;
  // per-item working registers
  logic signed [15:0] y_q, p_q, pcmd_q;
  logic               stale_q;
  logic signed [33:0] prod_q;
  logic signed [21:0] acc_q;

  logic signed [15:0] y_dz, p_dz;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic signed [17:0] sh16;
  logic signed [18:0] pf_sum;
  logic signed [15:0] pf_filt;
  logic        [31:0] age;
  logic signed [21:0] yaw_raw;
  logic signed [22:0] yaw_diff;
  logic signed [16:0] pitch_diff;

  assign y_dz = dz_apply(in_i.yaw_error, cfg_i.dead_zone);
  assign p_dz = dz_apply(in_i.pitch_error, cfg_i.dead_zone);

  always_comb begin
    unique case (uword_i.mul_a)
      MA_YAW:   mul_a = {y_q[15], y_q};
      MA_YDIFF: mul_a = {y_q[15], y_q} - {prev_q[15], prev_q};
      MA_PDIFF: mul_a = {p_q[15], p_q} - {pf_q[15], pf_q};
      MA_PF:    mul_a = {pf_q[15], pf_q};
      default:  mul_a = '0;
    endcase
    unique case (uword_i.mul_b)
      MB_KP:    mul_b = {cfg_i.yaw_prop_gain[15], cfg_i.yaw_prop_gain};
      MB_KD:    mul_b = {cfg_i.yaw_deriv_gain[15], cfg_i.yaw_deriv_gain};
      MB_ALPHA: mul_b = {1'b0, cfg_i.smooth_factor};
      MB_DECAY: mul_b = {1'b0, cfg_i.decay_factor};
      default:  mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  // floor(x / 2^16) of the registered product
  assign sh16    = prod_q[33:16];
  // pf*(1-alpha) + p*alpha == pf + (p-pf)*alpha
  assign pf_sum  = {{3{pf_q[15]}}, pf_q} + {sh16[17], sh16};
  assign pf_filt = gapd_sat16({{5{pf_sum[18]}}, pf_sum});
  assign age     = in_i.now_ms - last_q;

  always_comb begin
    pf_d   = pf_q;
    prev_d = prev_q;
    last_d = last_q;
    if (go_i) begin
      if (uword_i.prep && !in_i.shutdown && ((y_dz != 16'sd0) || (p_dz != 16'sd0))) begin
        last_d = in_i.now_ms;
      end
      if (uword_i.pf_upd) begin
        pf_d = pf_filt;
      end
      if (uword_i.decay && stale_q) begin
        pf_d = gapd_sat16({{6{sh16[17]}}, sh16});
      end
      if (uword_i.prev_upd) begin
        prev_d = y_q;
      end
      if (uword_i.shut) begin
        prev_d = 16'sd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_q   <= 16'sd0;
      prev_q <= 16'sd0;
      last_q <= 32'd0;
    end else begin
      pf_q   <= pf_d;
      prev_q <= prev_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      if (uword_i.prep) begin
        y_q <= y_dz;
        p_q <= p_dz;
      end
      if (uword_i.age) begin
        stale_q <= (age > {16'd0, cfg_i.stale_limit_ms});
      end
      if (uword_i.mul_en) begin
        prod_q <= prod;
      end
      unique case (uword_i.acc_op)
        ACC_LOAD: acc_q <= prod_q[33:12];
        ACC_ADD:  acc_q <= acc_q + prod_q[33:12];
        ACC_NONE: acc_q <= acc_q;
        default:  acc_q <= acc_q;
      endcase
      if (uword_i.pf_upd) begin
        pcmd_q <= pf_filt;
      end
    end
  end

  assign yaw_raw    = stale_q ? 22'sd0 : acc_q;
  assign yaw_diff   = {yaw_raw[21], yaw_raw}
                    - {{7{cfg_i.yaw_trim[15]}}, cfg_i.yaw_trim};
  assign pitch_diff = {pcmd_q[15], pcmd_q} - {cfg_i.pitch_trim[15], cfg_i.pitch_trim};

  always_comb begin
    res_o.firing = in_i.aim_fire & in_i.trigger_held;
    if (uword_i.shut) begin
      res_o.gimbal_enabled = 1'b0;
      res_o.pitch_cmd      = 16'sd0;
      res_o.yaw_cmd        = 16'sd0;
    end else begin
      res_o.gimbal_enabled = 1'b1;
      res_o.pitch_cmd      = gapd_sat16({{7{pitch_diff[16]}}, pitch_diff});
      res_o.yaw_cmd        = gapd_sat16({yaw_diff[22], yaw_diff});
    end
  end

endmodule
